// File: rtl/pfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfr_pkg
// shared types and codes of the page-mode frame buffer refresh block
// ----------------------------------------------------------------------------
package pfr_pkg;

    // operation codes carried in s_tuser
    localparam logic [2:0] FUNC_DRAW    = 3'd0;
    localparam logic [2:0] FUNC_FILL    = 3'd1;
    localparam logic [2:0] FUNC_CLEAR   = 3'd2;
    localparam logic [2:0] FUNC_REFRESH = 3'd3;
    localparam logic [2:0] FUNC_TICK    = 3'd4;

    // panel command bytes
    localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [7:0] CMD_COL_LOW   = 8'h00;
    localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

    localparam logic [7:0] FILL_BYTE  = 8'hFF;
    localparam logic [7:0] CLEAR_BYTE = 8'h00;

    // command slots ahead of the data bytes of every page
    localparam int CMD_SLOTS = 3;

    // decoded transaction handed from the sequencer to the data stage
    typedef struct packed {
        logic       write;    // read-modify-write of one byte
        logic       emit;     // produces one output transaction
        logic       is_data;  // output byte comes from the store
        logic       last;     // final data byte of the last page
        logic       color;
        logic [2:0] bit_sel;
        logic [7:0] cmd;
    } pfr_op_t;

    // request to sweep the whole store with one value
    typedef struct packed {
        logic       start;
        logic [7:0] value;
    } pfr_fill_t;

endpackage

`default_nettype wire

// File: rtl/pfr_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfr_store
// frame byte memory, one read and one write port, with a fill/clear sweep
// ----------------------------------------------------------------------------
module pfr_store #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire pfr_pkg::pfr_fill_t fill_req,
    input  wire                    wr_en,
    input  wire [ADDR_W-1:0]       wr_addr,
    input  wire [7:0]              wr_data,
    input  wire                    rd_en,
    input  wire [ADDR_W-1:0]       rd_addr,
    output logic [7:0]             rd_data,
    output logic                   sweep_busy
);
    import pfr_pkg::*;

    logic [7:0]        mem [DEPTH];
    logic [7:0]        rd_data_reg;
    logic              sweep_busy_reg;
    logic [ADDR_W-1:0] sweep_addr_reg;
    logic [7:0]        sweep_value_reg;

    // sweep control, reset starts a clearing pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_busy_reg  <= 1'b1;
            sweep_addr_reg  <= '0;
            sweep_value_reg <= CLEAR_BYTE;
        end else if (fill_req.start) begin
            sweep_busy_reg  <= 1'b1;
            sweep_addr_reg  <= '0;
            sweep_value_reg <= fill_req.value;
        end else if (sweep_busy_reg) begin
            if (sweep_addr_reg == ADDR_W'(DEPTH - 1)) begin
                sweep_busy_reg <= 1'b0;
            end else begin
                sweep_addr_reg <= sweep_addr_reg + 1'b1;
            end
        end
    end

    // write port, sweep and pixel writes never overlap
    always_ff @(posedge aclk) begin
        if (sweep_busy_reg) begin
            mem[sweep_addr_reg] <= sweep_value_reg;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data    = rd_data_reg;
    assign sweep_busy = sweep_busy_reg;

endmodule

`default_nettype wire

// File: rtl/pfr_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfr_seq
// decodes input transactions and steps the page/slot refresh counters
// ----------------------------------------------------------------------------
module pfr_seq #(
    parameter int COLUMNS = 128,
    parameter int ROWS    = 64,
    parameter int ADDR_W  = 10
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     take,
    input  wire [2:0]               func,
    input  wire [7:0]               pos_x,
    input  wire [7:0]               pos_y,
    input  wire                     color,
    output pfr_pkg::pfr_op_t        op,
    output logic [ADDR_W-1:0]       addr,
    output pfr_pkg::pfr_fill_t      fill_req
);
    import pfr_pkg::*;

    localparam int PAGES  = (ROWS + 7) / 8;
    localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int SLOT_W = $clog2(COLUMNS + CMD_SLOTS);

    logic              busy_reg, busy_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              slot_end;
    logic              page_end;
    logic              in_range;
    logic [ADDR_W-1:0] draw_addr;
    logic [ADDR_W-1:0] data_addr;

    assign slot_end  = (int'(slot_reg) == COLUMNS + CMD_SLOTS - 1);
    assign page_end  = (int'(page_reg) == PAGES - 1);
    assign in_range  = (int'(pos_x) < COLUMNS) && (int'(pos_y) < ROWS);
    assign draw_addr = ADDR_W'(int'(pos_x) + COLUMNS * int'(pos_y[7:3]));
    assign data_addr = ADDR_W'(int'(page_reg) * COLUMNS + int'(slot_reg) - CMD_SLOTS);

    always_comb begin
        op.write   = (func == FUNC_DRAW) && in_range;
        op.emit    = (func == FUNC_TICK) && busy_reg;
        op.is_data = (int'(slot_reg) >= CMD_SLOTS);
        op.last    = slot_end && page_end;
        op.color   = color;
        op.bit_sel = pos_y[2:0];
        case (slot_reg)
            SLOT_W'(0): op.cmd = CMD_PAGE_BASE + 8'(page_reg);
            SLOT_W'(1): op.cmd = CMD_COL_LOW;
            SLOT_W'(2): op.cmd = CMD_COL_HIGH;
            default:    op.cmd = CMD_COL_LOW;
        endcase
        addr = (func == FUNC_DRAW) ? draw_addr : data_addr;
        fill_req.start = take && ((func == FUNC_FILL) || (func == FUNC_CLEAR));
        fill_req.value = (func == FUNC_FILL) ? FILL_BYTE : CLEAR_BYTE;
    end

    always_comb begin
        busy_next = busy_reg;
        page_next = page_reg;
        slot_next = slot_reg;
        if (take) begin
            case (func)
                FUNC_FILL, FUNC_CLEAR, FUNC_REFRESH: begin
                    busy_next = 1'b1;
                    page_next = '0;
                    slot_next = '0;
                end
                FUNC_TICK: begin
                    if (busy_reg) begin
                        if (slot_end) begin
                            slot_next = '0;
                            if (page_end) begin
                                busy_next = 1'b0;
                                page_next = '0;
                            end else begin
                                page_next = page_reg + 1'b1;
                            end
                        end else begin
                            slot_next = slot_reg + 1'b1;
                        end
                    end
                end
                default: begin
                    busy_next = busy_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            page_reg <= '0;
            slot_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            page_reg <= page_next;
            slot_reg <= slot_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/page_framebuffer_refresh.sv
`default_nettype none
// ----------------------------------------------------------------------------
// page_framebuffer_refresh
// monochrome page-mode frame buffer with a tick-paced panel refresh stream
// ----------------------------------------------------------------------------
//  channel  dir  tdata                       tuser          tlast
//  s_       in   [7:0] pos_x [15:8] pos_y    [2:0] func     -
//                [16] color
//  m_       out  [7:0] byte_value            [0] is_data    last
//
//  draw, update and tick transactions are taken one per cycle while s_tready
//  is high: a two stage path, sequencer plus store read, then modify/write back
//  or output; fill and clear are taken, then s_tready drops while the store
//  is swept one byte per cycle, COLUMNS*PAGES bytes (1024 by default)
//  after reset the same sweep clears the store before the first transaction
//  s_tready also drops while a result waits in the output register, m_tready
//  is low and another result sits in the data stage
// ----------------------------------------------------------------------------
module page_framebuffer_refresh #(
    parameter int COLUMNS = 128,
    parameter int ROWS    = 64
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire [23:0] s_tdata,   // pos_x, pos_y, color, zero fill
    input  wire [2:0]  s_tuser,   // func
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata,   // byte_value
    output logic [0:0] m_tuser,   // is_data
    output logic       m_tlast
);
    import pfr_pkg::*;

    localparam int PAGES  = (ROWS + 7) / 8;
    localparam int DEPTH  = COLUMNS * PAGES;
    localparam int ADDR_W = $clog2(DEPTH);

    // input field split
    logic [2:0] in_func;
    logic [7:0] in_pos_x;
    logic [7:0] in_pos_y;
    logic       in_color;

    assign in_func  = s_tuser;
    assign in_pos_x = s_tdata[7:0];
    assign in_pos_y = s_tdata[15:8];
    assign in_color = s_tdata[16];

    // sequencer outputs
    pfr_op_t           seq_op;
    logic [ADDR_W-1:0] seq_addr;
    pfr_fill_t         fill_req;

    // store ports
    logic [7:0]        rd_data;
    logic              sweep_busy;
    logic              wr_en;
    logic [7:0]        wr_data;

    // data stage
    logic              st1_valid_reg;
    pfr_op_t           st1_op_reg;
    logic [ADDR_W-1:0] st1_addr_reg;

    // write-back forwarding, covers a read issued on the cycle of a write
    logic              fwd_valid_reg, fwd_valid_next;
    logic [ADDR_W-1:0] fwd_addr_reg;
    logic [7:0]        fwd_data_reg;

    // output register
    logic              m_tvalid_reg;
    logic [7:0]        m_tdata_reg;
    logic              m_tuser_reg;
    logic              m_tlast_reg;

    logic              take;
    logic              stall;
    logic [7:0]        cur_byte;
    logic [7:0]        bit_mask;
    logic              emit_now;

    // data stage holds only when its result cannot enter the output register
    assign stall    = st1_valid_reg && st1_op_reg.emit && m_tvalid_reg && !m_tready;
    assign s_tready = !sweep_busy && !stall;
    assign take     = s_tvalid && s_tready;

    pfr_seq #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .ADDR_W  (ADDR_W)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .take     (take),
        .func     (in_func),
        .pos_x    (in_pos_x),
        .pos_y    (in_pos_y),
        .color    (in_color),
        .op       (seq_op),
        .addr     (seq_addr),
        .fill_req (fill_req)
    );

    pfr_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fill_req   (fill_req),
        .wr_en      (wr_en),
        .wr_addr    (st1_addr_reg),
        .wr_data    (wr_data),
        .rd_en      (!stall),
        .rd_addr    (seq_addr),
        .rd_data    (rd_data),
        .sweep_busy (sweep_busy)
    );

    // current byte: memory data unless the previous write hit the same byte
    assign cur_byte = (fwd_valid_reg && (fwd_addr_reg == st1_addr_reg)) ?
                      fwd_data_reg : rd_data;
    assign bit_mask = 8'd1 << st1_op_reg.bit_sel;
    assign wr_data  = st1_op_reg.color ? (cur_byte | bit_mask) : (cur_byte & ~bit_mask);
    assign wr_en    = st1_valid_reg && st1_op_reg.write;
    assign emit_now = st1_valid_reg && st1_op_reg.emit && !stall;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (!stall) begin
            st1_valid_reg <= take;
        end
    end

    always_ff @(posedge aclk) begin
        if (!stall) begin
            st1_op_reg   <= seq_op;
            st1_addr_reg <= seq_addr;
        end
    end

    always_comb begin
        fwd_valid_next = fwd_valid_reg;
        if (sweep_busy) begin
            fwd_valid_next = 1'b0;
        end else if (!stall) begin
            fwd_valid_next = wr_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else begin
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            fwd_addr_reg <= st1_addr_reg;
            fwd_data_reg <= wr_data;
        end
    end

    // output register, loads whenever it is empty or being drained
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit_now) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_now) begin
            m_tdata_reg <= st1_op_reg.is_data ? cur_byte : st1_op_reg.cmd;
            m_tuser_reg <= st1_op_reg.is_data;
            m_tlast_reg <= st1_op_reg.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // pixel write-back never collides with a store sweep
    a_no_write_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> !sweep_busy)
        else $error("pixel write during store sweep");

    // an accepted fill or clear starts the sweep on the next cycle
    a_fill_starts_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && ((in_func == FUNC_FILL) || (in_func == FUNC_CLEAR))) |=> sweep_busy)
        else $error("fill or clear did not start a sweep");

    // the frame end marker rides only on data bytes
    a_last_is_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tuser[0])
        else $error("last marker on a command byte");

    // a stalled result in the data stage keeps its decoded op
    a_stall_holds_op: assert property (@(posedge aclk) disable iff (!aresetn)
        stall |=> (st1_valid_reg && $stable(st1_op_reg) && $stable(st1_addr_reg)))
        else $error("data stage changed while stalled");

endmodule

`default_nettype wire

// File: dv/tb_page_framebuffer_refresh.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_page_framebuffer_refresh
// self-checking bench for the page-mode frame buffer refresh block
// ----------------------------------------------------------------------------
// A shadow frame buffer and refresh sequencer predicts every panel byte when
// an input transaction is accepted. The monitor compares each output
// transaction with the oldest predicted byte.
// Stimulus is a short directed list, then one complete frame refresh. After
// that come random episodes: mostly a start (update, fill or clear), then
// ticks mixed with pixel draws, stray codes and restarts. Both channels
// stall at random in the first two of three phases.
// ----------------------------------------------------------------------------
module tb_page_framebuffer_refresh;
    import pfr_pkg::*;

    localparam int COLUMNS     = 128;
    localparam int ROWS        = 64;
    localparam int PAGES       = (ROWS + 7) / 8;
    localparam int STORE_BYTES = COLUMNS * PAGES;
    localparam int PAGE_SLOTS  = CMD_SLOTS + COLUMNS;

    // func codes the block must ignore
    localparam logic [2:0] FUNC_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] FUNC_LAST_UNUSED  = 3'd7;

    localparam int RANDOM_ITEMS = 750;
    // quiet cycles at the end: long enough for a whole fill/clear sweep
    localparam int DRAIN_CYCLES = STORE_BYTES + 200;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic       color;
    } panel_req_t;

    typedef struct packed {
        logic       is_data;
        logic [7:0] byte_value;
        logic       last;
    } panel_byte_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    page_framebuffer_refresh #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // pos_x, pos_y, color, zero fill
        .s_tuser  (s_tuser),   // func
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // byte_value
        .m_tuser  (m_tuser),   // is_data
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    // pending input transactions and predicted panel bytes
    panel_req_t  req_queue[$];
    panel_byte_t panel_bytes_due[$];

    int error_count  = 0;
    int sent_count   = 0;
    int total_items  = 1;
    int load_phase   = 0;
    int episode_ticks;

    // shadow copy of the block state
    logic [7:0] shadow_frame [STORE_BYTES];
    logic       shadow_busy;
    int         shadow_page;
    int         shadow_slot;

    // stall rates per phase: receiver slow first, then sender, then none
    function automatic int send_idle_pct(input int phase);
        case (phase)
            0:       return 28;
            1:       return 63;
            default: return 0;
        endcase
    endfunction

    function automatic int recv_idle_pct(input int phase);
        case (phase)
            0:       return 63;
            1:       return 28;
            default: return 0;
        endcase
    endfunction

    function automatic void reset_shadow();
        for (int i = 0; i < STORE_BYTES; i++) shadow_frame[i] = CLEAR_BYTE;
        shadow_busy = 1'b0;
        shadow_page = 0;
        shadow_slot = 0;
    endfunction

    function automatic void start_shadow_refresh();
        shadow_busy = 1'b1;
        shadow_page = 0;
        shadow_slot = 0;
    endfunction

    // applies one request to the shadow state, returns 1 with the panel byte
    // a tick produces while a refresh runs
    function automatic bit predict_panel_byte(input panel_req_t req,
                                              output panel_byte_t res);
        int idx;
        res = '0;
        case (req.func)
            FUNC_DRAW: begin
                if (req.pos_x < COLUMNS && req.pos_y < ROWS) begin
                    idx = int'(req.pos_x) + COLUMNS * int'(req.pos_y >> 3);
                    shadow_frame[idx][req.pos_y[2:0]] = req.color;
                end
                return 1'b0;
            end
            FUNC_FILL: begin
                for (int i = 0; i < STORE_BYTES; i++) shadow_frame[i] = FILL_BYTE;
                start_shadow_refresh();
                return 1'b0;
            end
            FUNC_CLEAR: begin
                for (int i = 0; i < STORE_BYTES; i++) shadow_frame[i] = CLEAR_BYTE;
                start_shadow_refresh();
                return 1'b0;
            end
            FUNC_REFRESH: begin
                start_shadow_refresh();
                return 1'b0;
            end
            FUNC_TICK: begin
                if (!shadow_busy) return 1'b0;
                if (shadow_slot == 0) begin
                    res.byte_value = CMD_PAGE_BASE + 8'(shadow_page);
                end else if (shadow_slot == 1) begin
                    res.byte_value = CMD_COL_LOW;
                end else if (shadow_slot == 2) begin
                    res.byte_value = CMD_COL_HIGH;
                end else begin
                    res.is_data    = 1'b1;
                    res.byte_value = shadow_frame[shadow_page * COLUMNS
                                                  + shadow_slot - CMD_SLOTS];
                end
                shadow_slot++;
                if (shadow_slot >= PAGE_SLOTS) begin
                    shadow_slot = 0;
                    if (shadow_page + 1 >= PAGES) begin
                        res.last    = 1'b1;
                        shadow_busy = 1'b0;
                        shadow_page = 0;
                    end else begin
                        shadow_page++;
                    end
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic push_req(input logic [2:0] func, input logic [7:0] x,
                            input logic [7:0] y, input logic color);
        panel_req_t r;
        r.func  = func;
        r.pos_x = x;
        r.pos_y = y;
        r.color = color;
        req_queue.push_back(r);
    endtask

    // an optional start, then ticks, draws, stray codes and restarts; a whole-frame
    // episode always starts, has enough ticks to finish page 7, never restarts midway
    task automatic queue_episode(input bit whole_frame, inout int count);
        int n;
        int pick;
        n = whole_frame ? 0 : $urandom_range(1, 260);
        pick = $urandom_range(9);
        if (whole_frame || $urandom_range(9) != 0) begin
            if (pick < 6)
                push_req(FUNC_REFRESH, 8'($urandom), 8'($urandom), 1'($urandom));
            else if (pick < 8)
                push_req(FUNC_FILL, 8'($urandom), 8'($urandom), 1'($urandom));
            else
                push_req(FUNC_CLEAR, 8'($urandom), 8'($urandom), 1'($urandom));
            count++;
        end
        episode_ticks = 0;
        while (whole_frame ? (episode_ticks < PAGES * PAGE_SLOTS + 4) : (n > 0)) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                push_req(FUNC_TICK, 8'($urandom), 8'($urandom), 1'($urandom));
                episode_ticks++;
            end else if (pick < 88) begin
                push_req(FUNC_DRAW, 8'($urandom_range(COLUMNS - 1)),
                         8'($urandom_range(ROWS - 1)), 1'($urandom));
            end else if (pick < 94) begin
                // whole coordinate range, mostly out of bounds
                push_req(FUNC_DRAW, 8'($urandom_range(255)), 8'($urandom_range(255)),
                         1'($urandom));
            end else if (pick < 97 || whole_frame) begin
                push_req(3'($urandom_range(FUNC_FIRST_UNUSED, FUNC_LAST_UNUSED)),
                         8'($urandom), 8'($urandom), 1'($urandom));
            end else begin
                push_req(FUNC_REFRESH, 8'($urandom), 8'($urandom), 1'($urandom));
            end
            count++;
            n--;
        end
    endtask

    // driver: presents queued requests, predicts on every accepted one
    always @(posedge aclk) begin : drive_proc
        panel_req_t  acc;
        panel_req_t  nxt;
        panel_byte_t res;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                acc.func  = s_tuser;
                acc.pos_x = s_tdata[7:0];
                acc.pos_y = s_tdata[15:8];
                acc.color = s_tdata[16];
                if (predict_panel_byte(acc, res)) panel_bytes_due.push_back(res);
                sent_count++;
                load_phase <= (sent_count * 3) / total_items;
            end
            if (s_tvalid && !s_tready) begin
                // hold the transaction until taken
            end else if (req_queue.size() != 0
                         && $urandom_range(99) >= send_idle_pct(load_phase)) begin
                nxt = req_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.func;
                s_tdata  <= {7'd0, nxt.color, nxt.pos_y, nxt.pos_x};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: checks every output transaction against the oldest prediction
    always @(posedge aclk) begin : check_proc
        panel_byte_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (panel_bytes_due.size() == 0) begin
                    $error("unexpected panel byte %02h is_data %0d last %0d",
                           m_tdata, m_tuser[0], m_tlast);
                    error_count++;
                end else begin
                    want = panel_bytes_due.pop_front();
                    if (m_tuser[0] !== want.is_data) begin
                        $error("is_data expected %0d actual %0d", want.is_data, m_tuser[0]);
                        error_count++;
                    end
                    if (m_tdata !== want.byte_value) begin
                        $error("byte_value expected %02h actual %02h",
                               want.byte_value, m_tdata);
                        error_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last expected %0d actual %0d", want.last, m_tlast);
                        error_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct(load_phase));
        end
    end

    initial begin : main_proc
        int random_count;
        reset_shadow();

        // directed: tick while idle, corner pixels, out-of-range draws
        push_req(FUNC_TICK, 8'h00, 8'h00, 1'b0);
        push_req(FUNC_DRAW, 8'd0, 8'd0, 1'b1);
        push_req(FUNC_DRAW, 8'd127, 8'd63, 1'b1);
        push_req(FUNC_DRAW, 8'd128, 8'd0, 1'b1);
        push_req(FUNC_DRAW, 8'd0, 8'd64, 1'b1);
        push_req(FUNC_DRAW, 8'd255, 8'd255, 1'b1);
        // stray codes
        push_req(FUNC_FIRST_UNUSED, 8'hFF, 8'hFF, 1'b1);
        push_req(3'd6, 8'h55, 8'hAA, 1'b0);
        push_req(FUNC_LAST_UNUSED, 8'hAA, 8'h55, 1'b1);
        // update: three commands then the first data byte
        push_req(FUNC_REFRESH, 8'h00, 8'h00, 1'b0);
        repeat (4) push_req(FUNC_TICK, 8'h00, 8'h00, 1'b0);
        // restart in the middle of page 0
        push_req(FUNC_REFRESH, 8'h00, 8'h00, 1'b0);
        repeat (2) push_req(FUNC_TICK, 8'hFF, 8'hFF, 1'b1);
        // fill, then clear a pixel of a data byte not yet sent
        push_req(FUNC_FILL, 8'h00, 8'h00, 1'b0);
        repeat (4) push_req(FUNC_TICK, 8'h00, 8'h00, 1'b0);
        push_req(FUNC_DRAW, 8'd1, 8'd0, 1'b0);
        push_req(FUNC_TICK, 8'h00, 8'h00, 1'b0);
        push_req(FUNC_CLEAR, 8'h00, 8'h00, 1'b0);
        push_req(FUNC_TICK, 8'h00, 8'h00, 1'b0);

        // one complete refresh up to the final data byte, then random episodes
        random_count = 0;
        queue_episode(1'b1, random_count);
        random_count = 0;
        while (random_count < RANDOM_ITEMS) queue_episode(1'b0, random_count);
        total_items = req_queue.size();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // all stimulus accepted, then every predicted byte seen
        while (req_queue.size() != 0 || s_tvalid) @(negedge aclk);
        while (panel_bytes_due.size() != 0) @(negedge aclk);
        // stay open for stray output after the last prediction
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (error_count == 0 && panel_bytes_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog: a few times the slowest expected run
    initial begin : watchdog_proc
        #8000000;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
rtl/pfr_pkg.sv
rtl/pfr_store.sv
rtl/pfr_seq.sv
rtl/page_framebuffer_refresh.sv
dv/tb_page_framebuffer_refresh.sv
